// ===== rtl/dimt_pkg.sv =====
// shared types and constants for the device-id table match block
// entry and descriptor layouts, field-enable bit positions, operation codes
// no dependencies
package dimt_pkg;

  // operation codes carried in op
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // bit positions inside the match-enable flags
  localparam int FLAG_VENDOR     = 0;
  localparam int FLAG_PRODUCT    = 1;
  localparam int FLAG_REV_LO     = 2;
  localparam int FLAG_REV_HI     = 3;
  localparam int FLAG_DEV_CLASS  = 4;
  localparam int FLAG_DEV_SUB    = 5;
  localparam int FLAG_DEV_PROTO  = 6;
  localparam int FLAG_IF_CLASS   = 7;
  localparam int FLAG_IF_SUB     = 8;
  localparam int FLAG_IF_PROTO   = 9;

  // width of the index reported on the result beat
  localparam int IDX_OUT_W = 5;

  // one stored table entry
  typedef struct packed {
    logic        wild;
    logic [9:0]  flags;
    logic [15:0] vendor;
    logic [15:0] product;
    logic [15:0] rev_lo;
    logic [15:0] rev_hi;
    logic [23:0] dev_class;
    logic [23:0] if_class;
  } entry_t;

  // descriptor of the device being looked up
  typedef struct packed {
    logic [15:0] vendor;
    logic [15:0] product;
    logic [15:0] rev;
    logic [23:0] dev_class;
    logic [23:0] if_class;
  } desc_t;

  // verdict of the compare unit on one entry
  typedef struct packed {
    logic term;
    logic hit;
  } match_res_t;

endpackage

// ===== rtl/dimt_table.sv =====
// entry storage for the device-id table: one write port, one registered read
// per-entry valid bits make unwritten entries read as zero right after reset
// depends on dimt_pkg
module dimt_table
  import dimt_pkg::*;
#(
  parameter int DEPTH  = 32,
  parameter int ADDR_W = 5
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  entry_t            wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output entry_t            rd_data
);

  entry_t           mem [DEPTH];
  logic [DEPTH-1:0] valid;
  entry_t           rd_q;
  logic             rd_ok;

  // storage array, no reset
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  // valid bits, cleared together at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      rd_ok <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      rd_ok <= valid[rd_addr];
    end
  end

  // an entry never written reads as all zero
  assign rd_data = rd_ok ? rd_q : '0;

endmodule

// ===== rtl/dimt_match.sv =====
// compare unit shared by every step of the scan: tests one entry
// against the looked-up descriptor and flags terminator entries
// depends on dimt_pkg
module dimt_match
  import dimt_pkg::*;
(
  input  entry_t     entry,
  input  desc_t      desc,
  output match_res_t res
);

  logic ok_vendor;
  logic ok_product;
  logic ok_lo;
  logic ok_hi;
  logic ok_dev;
  logic ok_if;

  // terminator: no vendor, no classes, no wildcard mark
  always_comb begin
    res.term = (entry.vendor == '0) && (entry.dev_class[23:16] == '0) &&
               (entry.if_class[23:16] == '0) && !entry.wild;
  end

  // enabled field tests
  assign ok_vendor  = !entry.flags[FLAG_VENDOR]  || (entry.vendor == desc.vendor);
  assign ok_product = !entry.flags[FLAG_PRODUCT] || (entry.product == desc.product);
  assign ok_lo      = !entry.flags[FLAG_REV_LO]  || (entry.rev_lo <= desc.rev);
  assign ok_hi      = !entry.flags[FLAG_REV_HI]  || (entry.rev_hi >= desc.rev);

  // class, subclass and protocol bytes
  assign ok_dev =
    (!entry.flags[FLAG_DEV_CLASS] || entry.dev_class[23:16] == desc.dev_class[23:16]) &&
    (!entry.flags[FLAG_DEV_SUB]   || entry.dev_class[15:8]  == desc.dev_class[15:8])  &&
    (!entry.flags[FLAG_DEV_PROTO] || entry.dev_class[7:0]   == desc.dev_class[7:0]);
  assign ok_if =
    (!entry.flags[FLAG_IF_CLASS] || entry.if_class[23:16] == desc.if_class[23:16]) &&
    (!entry.flags[FLAG_IF_SUB]   || entry.if_class[15:8]  == desc.if_class[15:8])  &&
    (!entry.flags[FLAG_IF_PROTO] || entry.if_class[7:0]   == desc.if_class[7:0]);

  always_comb begin
    res.hit = !res.term && ok_vendor && ok_product && ok_lo && ok_hi && ok_dev && ok_if;
  end

endmodule

// ===== rtl/device_id_table_match_top.sv =====
// device-id table with first-match lookup: sequencer, entry memory, compare unit
// depends on dimt_pkg, dimt_table, dimt_match
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid, req_stall | op, entry_index, field_enable, vendor_id,
//           |           |                      | product_id, bcd_device, bcd_high,
//           |           |                      | device_class_code, interface_class_code,
//           |           |                      | wildcard_mark
//   rsp     | out       | rsp_valid, rsp_stall | found, match_index
//
// a write beat passes through the done state into the output register
// a lookup reads one entry per cycle through the single memory read port and the
// compare unit, visiting at most TABLE_DEPTH entries
// req_stall is high while an item is in flight and during reset
// reset clears the entry valid bits at once; no clearing pass is needed
// the next item is accepted while a finished result still waits on rsp_stall
module device_id_table_match_top
  import dimt_pkg::*;
#(
  parameter int TABLE_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic        op,
  input  logic [4:0]  entry_index,
  input  logic [9:0]  field_enable,
  input  logic [15:0] vendor_id,
  input  logic [15:0] product_id,
  input  logic [15:0] bcd_device,
  input  logic [15:0] bcd_high,
  input  logic [23:0] device_class_code,
  input  logic [23:0] interface_class_code,
  input  logic        wildcard_mark,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic        found,
  output logic [4:0]  match_index
);

  localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_DEPTH - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]           state;
  desc_t                desc;
  logic [ADDR_W-1:0]    scan_addr;
  logic [ADDR_W-1:0]    chk_idx;
  logic                 chk_valid;
  logic                 res_found;
  logic [IDX_OUT_W-1:0] res_index;

  logic                 req_fire;
  logic                 wr_en;
  entry_t               wr_data;
  entry_t               rd_data;
  match_res_t           mres;

  assign req_stall = rst || (state != S_IDLE);
  assign req_fire  = req_valid && !req_stall;

  // write beats go straight into the table when the slot exists
  assign wr_en = req_fire && (op == OP_WRITE) && (32'(entry_index) < TABLE_DEPTH);

  always_comb begin
    wr_data.wild      = wildcard_mark;
    wr_data.flags     = field_enable;
    wr_data.vendor    = vendor_id;
    wr_data.product   = product_id;
    wr_data.rev_lo    = bcd_device;
    wr_data.rev_hi    = bcd_high;
    wr_data.dev_class = device_class_code;
    wr_data.if_class  = interface_class_code;
  end

  dimt_table #(
    .DEPTH  (TABLE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (ADDR_W'(entry_index)),
    .wr_data (wr_data),
    .rd_addr (scan_addr),
    .rd_data (rd_data)
  );

  dimt_match u_match (
    .entry (rd_data),
    .desc  (desc),
    .res   (mres)
  );

  // sequencer: reads run one entry ahead of the compare
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      chk_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            if (op == OP_LOOKUP) begin
              desc.vendor    <= vendor_id;
              desc.product   <= product_id;
              desc.rev       <= bcd_device;
              desc.dev_class <= device_class_code;
              desc.if_class  <= interface_class_code;
              scan_addr      <= '0;
              chk_valid      <= 1'b0;
              state          <= S_SCAN;
            end else begin
              res_found <= 1'b0;
              res_index <= '0;
              state     <= S_DONE;
            end
          end
        end
        S_SCAN: begin
          if (scan_addr != LAST_ADDR) begin
            scan_addr <= scan_addr + 1'b1;
          end
          chk_idx   <= scan_addr;
          chk_valid <= 1'b1;
          if (chk_valid) begin
            if (mres.term) begin
              res_found <= 1'b0;
              res_index <= '0;
              state     <= S_DONE;
            end else if (mres.hit) begin
              res_found <= 1'b1;
              res_index <= IDX_OUT_W'(chk_idx);
              state     <= S_DONE;
            end else if (chk_idx == LAST_ADDR) begin
              res_found <= 1'b0;
              res_index <= '0;
              state     <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result register: loads from the done state, empties on a taken beat
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((state == S_DONE) && (!rsp_valid || !rsp_stall)) begin
      rsp_valid   <= 1'b1;
      found       <= res_found;
      match_index <= res_index;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

endmodule

// ===== rtl/dimt_checker.sv =====
// port-level checks for the device-id table match block, bound to the top level
// depends on dimt_pkg and device_id_table_match_top
module dimt_checker
  import dimt_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_stall,
  input logic       rsp_valid,
  input logic       rsp_stall,
  input logic       found,
  input logic [4:0] match_index
);

  // a stalled result beat holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(found) && $stable(match_index))
    else $error("result beat changed while stalled");

  // a miss or a write always reports index zero
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !found |-> match_index == 5'd0)
    else $error("nonzero index on a miss");

  // one item at a time: the block is busy right after taking a beat
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("second beat accepted while busy");

  // a new result only appears after a busy cycle
  a_result_after_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_stall))
    else $error("result without an item in flight");

endmodule

bind device_id_table_match_top dimt_checker u_dimt_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req_valid),
  .req_stall   (req_stall),
  .rsp_valid   (rsp_valid),
  .rsp_stall   (rsp_stall),
  .found       (found),
  .match_index (match_index)
);

// ===== tb/tb_device_id_table_match_top.sv =====
`timescale 1ns / 100ps
// testbench for device_id_table_match_top: table writes and first-match lookups,
// each result beat scored against a table predictor updated on every accepted beat
// depends on dimt_pkg and the rtl of device_id_table_match_top
module tb_device_id_table_match_top
  import dimt_pkg::*;
();

  localparam int TABLE_DEPTH  = 32;
  localparam int PHASE_ITEMS  = 270;
  localparam int DRAIN_CYCLES = TABLE_DEPTH + 8;
  localparam int MAX_REPORTS  = 30;

  // one request beat as presented on the req channel
  typedef struct packed {
    logic        op;
    logic [4:0]  slot;
    logic [9:0]  flags;
    logic [15:0] vendor;
    logic [15:0] product;
    logic [15:0] rev;
    logic [15:0] rev_hi;
    logic [23:0] dev_class;
    logic [23:0] if_class;
    logic        wild;
  } req_beat_t;

  // one result beat
  typedef struct packed {
    logic       found;
    logic [4:0] match_idx;
  } lookup_rsp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  logic        op = OP_WRITE;
  logic [4:0]  entry_index = '0;
  logic [9:0]  field_enable = '0;
  logic [15:0] vendor_id = '0;
  logic [15:0] product_id = '0;
  logic [15:0] bcd_device = '0;
  logic [15:0] bcd_high = '0;
  logic [23:0] device_class_code = '0;
  logic [23:0] interface_class_code = '0;
  logic        wildcard_mark = 1'b0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  logic        found;
  logic [4:0]  match_index;

  req_beat_t   pending_q[$];
  lookup_rsp_t expected_rsp_q[$];
  entry_t      table_model [TABLE_DEPTH];   // predictor copy, follows accepted beats
  entry_t      planned_table [TABLE_DEPTH]; // generator view, used to aim lookups
  req_beat_t   bus_beat;
  lookup_rsp_t want;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int beats_queued = 0;
  int beats_checked = 0;
  int error_count = 0;
  int writes_seen = 0;
  int lookups_seen = 0;
  int hits_seen = 0;
  int deepest_hit = 0;

  device_id_table_match_top #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk                  (clk),
    .rst                  (rst),
    .req_valid            (req_valid),
    .req_stall            (req_stall),
    .op                   (op),
    .entry_index          (entry_index),
    .field_enable         (field_enable),
    .vendor_id            (vendor_id),
    .product_id           (product_id),
    .bcd_device           (bcd_device),
    .bcd_high             (bcd_high),
    .device_class_code    (device_class_code),
    .interface_class_code (interface_class_code),
    .wildcard_mark        (wildcard_mark),
    .rsp_valid            (rsp_valid),
    .rsp_stall            (rsp_stall),
    .found                (found),
    .match_index          (match_index)
  );

  // 10 ns clock
  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(string what, int got, int exp_val);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("%0t mismatch on %s: got %0d, expected %0d (result beat %0d)",
               $time, what, got, exp_val, beats_checked);
  endtask

  // table predictor: writes fill a slot, lookups scan for the first masked match
  task automatic predict_table_beat(req_beat_t b);
    lookup_rsp_t r;
    entry_t      e;
    logic        ok;
    r = '0;
    if (b.op == OP_WRITE) begin
      if (b.slot < TABLE_DEPTH) begin
        e.wild      = b.wild;
        e.flags     = b.flags;
        e.vendor    = b.vendor;
        e.product   = b.product;
        e.rev_lo    = b.rev;
        e.rev_hi    = b.rev_hi;
        e.dev_class = b.dev_class;
        e.if_class  = b.if_class;
        table_model[b.slot] = e;
      end
      writes_seen++;
    end else begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        e = table_model[i];
        // terminator: no vendor, no class bytes, no wildcard mark
        if (e.vendor == 16'h0 && e.dev_class[23:16] == 8'h0 &&
            e.if_class[23:16] == 8'h0 && !e.wild)
          break;
        ok = 1'b1;
        if (e.flags[FLAG_VENDOR] && e.vendor != b.vendor) ok = 1'b0;
        if (e.flags[FLAG_PRODUCT] && e.product != b.product) ok = 1'b0;
        if (e.flags[FLAG_REV_LO] && e.rev_lo > b.rev) ok = 1'b0;
        if (e.flags[FLAG_REV_HI] && e.rev_hi < b.rev) ok = 1'b0;
        if (e.flags[FLAG_DEV_CLASS] && e.dev_class[23:16] != b.dev_class[23:16]) ok = 1'b0;
        if (e.flags[FLAG_DEV_SUB] && e.dev_class[15:8] != b.dev_class[15:8]) ok = 1'b0;
        if (e.flags[FLAG_DEV_PROTO] && e.dev_class[7:0] != b.dev_class[7:0]) ok = 1'b0;
        if (e.flags[FLAG_IF_CLASS] && e.if_class[23:16] != b.if_class[23:16]) ok = 1'b0;
        if (e.flags[FLAG_IF_SUB] && e.if_class[15:8] != b.if_class[15:8]) ok = 1'b0;
        if (e.flags[FLAG_IF_PROTO] && e.if_class[7:0] != b.if_class[7:0]) ok = 1'b0;
        if (ok) begin
          r.found = 1'b1;
          r.match_idx = i[IDX_OUT_W-1:0];
          break;
        end
      end
      lookups_seen++;
    end
    expected_rsp_q.push_back(r);
  endtask

  function automatic entry_t mk_entry(logic [9:0] flags, logic wild, logic [15:0] vendor,
                                      logic [15:0] product, logic [15:0] rev_lo,
                                      logic [15:0] rev_hi, logic [23:0] dev_class,
                                      logic [23:0] if_class);
    entry_t e;
    e.wild      = wild;
    e.flags     = flags;
    e.vendor    = vendor;
    e.product   = product;
    e.rev_lo    = rev_lo;
    e.rev_hi    = rev_hi;
    e.dev_class = dev_class;
    e.if_class  = if_class;
    return e;
  endfunction

  // random entry; a few are terminators when may_end is set
  function automatic entry_t random_entry(logic may_end);
    entry_t e;
    int     pick;
    pick        = $urandom_range(99, 0);
    e.wild      = ($urandom_range(9, 0) == 0);
    e.flags     = 10'($urandom_range(1023, 0));
    e.vendor    = 16'($urandom);
    e.product   = 16'($urandom);
    e.rev_lo    = 16'($urandom);
    e.rev_hi    = $urandom_range(1, 0) ? 16'($urandom) : 16'(e.rev_lo + $urandom_range(255, 0));
    e.dev_class = 24'($urandom);
    e.if_class  = 24'($urandom);
    if (may_end && pick < 4) begin
      // terminator, lower class bytes left random
      e.vendor          = 16'h0;
      e.dev_class[23:16] = 8'h0;
      e.if_class[23:16]  = 8'h0;
      e.wild            = 1'b0;
    end else if (pick < 12) begin
      // no vendor: kept alive by a class byte or the wildcard mark
      e.vendor = 16'h0;
      if (pick < 7) e.wild = 1'b1;
      if (!e.wild && e.dev_class[23:16] == 8'h0 && e.if_class[23:16] == 8'h0)
        e.dev_class[16] = 1'b1;
    end
    return e;
  endfunction

  task automatic queue_entry_write(logic [4:0] slot, entry_t e);
    req_beat_t b;
    b.op        = OP_WRITE;
    b.slot      = slot;
    b.flags     = e.flags;
    b.vendor    = e.vendor;
    b.product   = e.product;
    b.rev       = e.rev_lo;
    b.rev_hi    = e.rev_hi;
    b.dev_class = e.dev_class;
    b.if_class  = e.if_class;
    b.wild      = e.wild;
    pending_q.push_back(b);
    planned_table[slot] = e;
    beats_queued++;
  endtask

  // write-only fields get random junk, the block must ignore them
  task automatic queue_lookup(logic [15:0] vendor, logic [15:0] product, logic [15:0] rev,
                              logic [23:0] dev_class, logic [23:0] if_class);
    req_beat_t b;
    b.op        = OP_LOOKUP;
    b.slot      = 5'($urandom);
    b.flags     = 10'($urandom);
    b.vendor    = vendor;
    b.product   = product;
    b.rev       = rev;
    b.rev_hi    = 16'($urandom);
    b.dev_class = dev_class;
    b.if_class  = if_class;
    b.wild      = 1'($urandom);
    pending_q.push_back(b);
    beats_queued++;
  endtask

  // lookups, most aimed at stored entries, mixed with writes, fill runs and noise
  task automatic queue_random_phase(int count);
    int          target;
    int          kind;
    int          s;
    int          n;
    entry_t      e;
    logic [15:0] v;
    logic [15:0] p;
    logic [15:0] r;
    logic [23:0] dc;
    logic [23:0] ic;
    target = beats_queued + count;
    while (beats_queued < target) begin
      kind = $urandom_range(99, 0);
      if (kind < 10) begin
        // contiguous run of live entries
        s = $urandom_range(TABLE_DEPTH - 1, 0);
        n = $urandom_range(8, 1);
        for (int k = 0; k < n && s + k < TABLE_DEPTH; k++)
          queue_entry_write(5'(s + k), random_entry(1'b0));
      end else if (kind < 40) begin
        queue_entry_write(5'($urandom_range(TABLE_DEPTH - 1, 0)), random_entry(1'b1));
      end else if (kind < 85) begin
        // descriptor copied from a stored entry, revision near or inside its window
        e  = planned_table[$urandom_range(TABLE_DEPTH - 1, 0)];
        v  = e.vendor;
        p  = e.product;
        dc = e.dev_class;
        ic = e.if_class;
        r  = 16'($urandom);
        if (e.rev_lo <= e.rev_hi) r = 16'($urandom_range(e.rev_hi, e.rev_lo));
        case ($urandom_range(7, 0))
          0: r = e.rev_lo;
          1: r = e.rev_hi;
          2: r = e.rev_lo - 16'h1;
          3: r = e.rev_hi + 16'h1;
          default: ;
        endcase
        // near miss: one bit off in one compared field
        if ($urandom_range(3, 0) == 0) begin
          case ($urandom_range(3, 0))
            0: v ^= 16'h1 << $urandom_range(15, 0);
            1: p ^= 16'h1 << $urandom_range(15, 0);
            2: dc ^= 24'h1 << $urandom_range(23, 0);
            default: ic ^= 24'h1 << $urandom_range(23, 0);
          endcase
        end
        queue_lookup(v, p, r, dc, ic);
      end else begin
        queue_lookup(16'($urandom), 16'($urandom), 16'($urandom), 24'($urandom),
                     24'($urandom));
      end
    end
  endtask

  // request driver: predicts on each taken beat, then offers the next one
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      for (int i = 0; i < TABLE_DEPTH; i++) table_model[i] = '0;
    end else begin
      if (req_valid && !req_stall) predict_table_beat(bus_beat);
      if (!req_valid || !req_stall) begin
        if (pending_q.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          bus_beat = pending_q.pop_front();
          req_valid            <= 1'b1;
          op                   <= bus_beat.op;
          entry_index          <= bus_beat.slot;
          field_enable         <= bus_beat.flags;
          vendor_id            <= bus_beat.vendor;
          product_id           <= bus_beat.product;
          bcd_device           <= bus_beat.rev;
          bcd_high             <= bus_beat.rev_hi;
          device_class_code    <= bus_beat.dev_class;
          interface_class_code <= bus_beat.if_class;
          wildcard_mark        <= bus_beat.wild;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: compares each taken beat with the oldest expectation
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsp_q.size() == 0) begin
          report_mismatch("result beat with none expected", int'(found), 0);
        end else begin
          want = expected_rsp_q.pop_front();
          if (found !== want.found)
            report_mismatch("found", int'(found), int'(want.found));
          if (match_index !== want.match_idx)
            report_mismatch("match_index", int'(match_index), int'(want.match_idx));
          if (want.found) begin
            hits_seen++;
            if (int'(want.match_idx) > deepest_hit) deepest_hit = int'(want.match_idx);
          end
          beats_checked++;
        end
      end
      rsp_stall <= ($urandom_range(99, 0) < recv_stall_pct);
    end
  end

  // stimulus and end of run
  initial begin
    for (int i = 0; i < TABLE_DEPTH; i++) planned_table[i] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // empty table: slot 0 already ends the scan
    queue_lookup(16'h0, 16'h0, 16'h0, 24'h0, 24'h0);
    // wildcard-only entry matches any device
    queue_entry_write(5'd0, mk_entry(10'h0, 1'b1, 16'h0, 16'h0, 16'h0, 16'h0, 24'h0, 24'h0));
    queue_lookup(16'hBEEF, 16'h1234, 16'h0100, 24'h0A0B0C, 24'h030201);
    // every field enabled, values at the extremes
    queue_entry_write(5'd0, mk_entry(10'h3FF, 1'b0, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF,
                                     24'hFFFFFF, 24'hFFFFFF));
    queue_lookup(16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF);
    queue_lookup(16'h0, 16'h0, 16'h0, 24'h0, 24'h0);
    // terminator despite nonzero subclass and protocol bytes, hides a wildcard behind it
    queue_entry_write(5'd1, mk_entry(10'h0, 1'b0, 16'h0, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                     24'h00FFFF, 24'h00FFFF));
    queue_entry_write(5'd2, mk_entry(10'h0, 1'b1, 16'h0, 16'h0, 16'h0, 16'h0, 24'h0, 24'h0));
    queue_lookup(16'h0, 16'h0, 16'h0, 24'h0, 24'h0);
    // vendor-less entry kept alive by its device class byte
    queue_entry_write(5'd1, mk_entry(10'h1 << FLAG_DEV_CLASS, 1'b0, 16'h0, 16'h0, 16'h0,
                                     16'h0, 24'h010000, 24'h0));
    queue_lookup(16'h0, 16'h0, 16'h0, 24'h01ABCD, 24'h0);
    queue_lookup(16'h0, 16'h0, 16'h0, 24'h02ABCD, 24'h0);
    // interface class, subclass and protocol compared
    queue_entry_write(5'd2, mk_entry((10'h1 << FLAG_IF_CLASS) | (10'h1 << FLAG_IF_SUB) |
                                     (10'h1 << FLAG_IF_PROTO), 1'b0, 16'h0, 16'h0, 16'h0,
                                     16'h0, 24'h0, 24'h80FF01));
    // revision window of a single value
    queue_entry_write(5'd3, mk_entry((10'h1 << FLAG_REV_LO) | (10'h1 << FLAG_REV_HI), 1'b0,
                                     16'h1234, 16'h0, 16'h1234, 16'h1234, 24'h0, 24'h0));
    queue_lookup(16'h0, 16'h0, 16'h1234, 24'h0, 24'h0);
    queue_lookup(16'h0, 16'h0, 16'h1233, 24'h0, 24'h0);
    queue_lookup(16'h0, 16'h0, 16'h1235, 24'h0, 24'h0);
    queue_lookup(16'h0, 16'h0, 16'h0, 24'h0, 24'h80FF01);
    queue_lookup(16'h0, 16'h0, 16'h0, 24'h0, 24'h80FF00);
    // inverted revision window never matches
    queue_entry_write(5'd4, mk_entry((10'h1 << FLAG_REV_LO) | (10'h1 << FLAG_REV_HI), 1'b0,
                                     16'h0001, 16'h0, 16'hFFFF, 16'h0000, 24'h0, 24'h0));
    queue_lookup(16'h0, 16'h0, 16'hFFFF, 24'h0, 24'h0);
    queue_lookup(16'h0, 16'h0, 16'h0000, 24'h0, 24'h0);
    queue_entry_write(5'd31, random_entry(1'b0));

    // handshake mixes: none, sender gaps, receiver stalls, both
    for (int ph = 0; ph < 4; ph++) begin
      while (beats_checked < beats_queued) @(negedge clk);
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      // first pass fills the whole table so scans run deep
      if (ph == 0) begin
        for (int i = 0; i < TABLE_DEPTH; i++) queue_entry_write(5'(i), random_entry(1'b0));
      end
      queue_random_phase(PHASE_ITEMS);
    end

    while (beats_checked < beats_queued) @(negedge clk);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_rsp_q.size() != 0)
      report_mismatch("results never returned", 0, expected_rsp_q.size());

    $display("covered %0d table writes and %0d lookups under four handshake mixes",
             writes_seen, lookups_seen);
    $display("%0d lookups matched, deepest matching slot %0d", hits_seen, deepest_hit);
    if (error_count == 0) begin
      $display("PASS device_id_table_match_top");
    end else begin
      $display("FAIL device_id_table_match_top");
    end
    $finish;
  end

  // run limit, far above the slowest legal run
  initial begin
    #4_000_000;
    $display("FAIL device_id_table_match_top");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/dimt_pkg.sv
rtl/dimt_table.sv
rtl/dimt_match.sv
rtl/device_id_table_match_top.sv
rtl/dimt_checker.sv
tb/tb_device_id_table_match_top.sv
